### src/mepg_pkg.sv
// ----------------------------------------------------------------------------
// mepg_pkg
// Shared constants for the midpoint ellipse point generator.
// ----------------------------------------------------------------------------
package mepg_pkg;

	localparam int COORD_BITS_DEF  = 8;
	localparam int RADIUS_BITS_DEF = 5;
	localparam int LIMIT_RESULTS   = 64;
	localparam int QUEUE_DEPTH     = 2;

endpackage

### src/mepg_if.sv
// ----------------------------------------------------------------------------
// mepg_if
// Valid/ready channels for ellipse requests and generated point sets.
// ----------------------------------------------------------------------------
interface mepg_in_if #(
	parameter int COORD_BITS  = mepg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mepg_pkg::RADIUS_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  center_x;
	logic [COORD_BITS-1:0]  center_y;
	logic [RADIUS_BITS-1:0] radius_x;
	logic [RADIUS_BITS-1:0] radius_y;

	modport source (output valid, center_x, center_y, radius_x, radius_y, input ready);
	modport sink   (input valid, center_x, center_y, radius_x, radius_y, output ready);
endinterface

interface mepg_out_if #(
	parameter int COORD_BITS  = mepg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mepg_pkg::RADIUS_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [RADIUS_BITS-1:0]       offset_x;
	logic [RADIUS_BITS-1:0]       offset_y;
	logic signed [COORD_BITS+1:0] x_plus;
	logic signed [COORD_BITS+1:0] x_minus;
	logic signed [COORD_BITS+1:0] y_plus;
	logic signed [COORD_BITS+1:0] y_minus;
	logic                         last_point;

	modport source (output valid, offset_x, offset_y, x_plus, x_minus, y_plus, y_minus,
		last_point, input ready);
	modport sink   (input valid, offset_x, offset_y, x_plus, x_minus, y_plus, y_minus,
		last_point, output ready);
endinterface

### src/mepg_front.sv
// ----------------------------------------------------------------------------
// mepg_front
// Accepts ellipse requests, squares the radii and forms a job word.
// ----------------------------------------------------------------------------
module mepg_front #(
	parameter int COORD_BITS  = mepg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mepg_pkg::RADIUS_BITS_DEF,
	parameter int JOB_BITS    = 2 * COORD_BITS + 5 * RADIUS_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	mepg_in_if.sink             ellipse,
	output logic                push_valid,
	input  logic                push_ready,
	output logic [JOB_BITS-1:0] push_job
);

	localparam int SQ = 2 * RADIUS_BITS;

	logic                valid_s1;
	logic [JOB_BITS-1:0] job_s1;
	logic [SQ-1:0]       a2;
	logic [SQ-1:0]       b2;
	logic                take;

	assign ellipse.ready = !valid_s1 || push_ready;
	assign take          = ellipse.valid && ellipse.ready;
	assign a2            = SQ'(ellipse.radius_x) * SQ'(ellipse.radius_x);
	assign b2            = SQ'(ellipse.radius_y) * SQ'(ellipse.radius_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ellipse.ready) begin
			valid_s1 <= ellipse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1 <= {ellipse.center_x, ellipse.center_y, ellipse.radius_y, a2, b2};
		end
	end

	assign push_valid = valid_s1;
	assign push_job   = job_s1;

endmodule

### src/mepg_queue.sv
// ----------------------------------------------------------------------------
// mepg_queue
// Short job queue between the request front and the point sequencer.
// ----------------------------------------------------------------------------
module mepg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mepg_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");
`endif

endmodule

### src/mepg_back.sv
// ----------------------------------------------------------------------------
// mepg_back
// Point sequencer: seeds the decision variables with a shared multiplier and
// walks both regions, one point set per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module mepg_back #(
	parameter int COORD_BITS  = mepg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mepg_pkg::RADIUS_BITS_DEF,
	parameter int JOB_BITS    = 2 * COORD_BITS + 5 * RADIUS_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  logic [JOB_BITS-1:0] pop_job,
	mepg_out_if.source          point
);

	localparam int R   = RADIUS_BITS;
	localparam int SQ  = 2 * R;
	localparam int OW  = COORD_BITS + 2;
	localparam int NW  = $clog2(mepg_pkg::LIMIT_RESULTS);
	localparam int XW  = NW + 1;
	localparam int YW  = R + 2;
	localparam int OPW = (2 * R + 1 > 16) ? 2 * R + 1 : 16;
	localparam int MW  = 2 * OPW;
	localparam int DW  = MW + 3;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SEED  = 11'b000_0000_0010,
		ST_INIT  = 11'b000_0000_0100,
		ST_REG1  = 11'b000_0000_1000,
		ST_SQX   = 11'b000_0001_0000,
		ST_MULB  = 11'b000_0010_0000,
		ST_SQY   = 11'b000_0100_0000,
		ST_MULA  = 11'b000_1000_0000,
		ST_MULAB = 11'b001_0000_0000,
		ST_FIN   = 11'b010_0000_0000,
		ST_REG2  = 11'b100_0000_0000
	} state_t;

	state_t                 state_q;
	logic [COORD_BITS-1:0]  cx_q;
	logic [COORD_BITS-1:0]  cy_q;
	logic [R-1:0]           b_q;
	logic [SQ-1:0]          a2_q;
	logic [SQ-1:0]          b2_q;
	logic [XW-1:0]          x_q;
	logic signed [YW-1:0]   y_q;
	logic signed [DW-1:0]   dx_q;
	logic signed [DW-1:0]   dy_q;
	logic signed [DW-1:0]   d_q;
	logic signed [MW-1:0]   prod_q;
	logic [NW-1:0]          n_q;

	logic                   out_valid_q;
	logic [R-1:0]           offset_x_q;
	logic [R-1:0]           offset_y_q;
	logic [OW-1:0]          x_plus_q;
	logic [OW-1:0]          x_minus_q;
	logic [OW-1:0]          y_plus_q;
	logic [OW-1:0]          y_minus_q;
	logic                   last_q;

	logic signed [OPW-1:0]  op_a;
	logic signed [OPW-1:0]  op_b;
	logic signed [DW-1:0]   a2_w;
	logic signed [DW-1:0]   b2_w;
	logic signed [DW-1:0]   prod_w;
	logic signed [DW-1:0]   dx_n;
	logic signed [DW-1:0]   dy_n;
	logic                   out_free;
	logic                   walk1;
	logic                   emit;
	logic                   at_limit;
	logic                   last_w;

	assign a2_w     = DW'($signed({1'b0, a2_q}));
	assign b2_w     = DW'($signed({1'b0, b2_q}));
	assign prod_w   = DW'(prod_q);
	assign dx_n     = dx_q + b2_w + b2_w;
	assign dy_n     = dy_q - a2_w - a2_w;
	assign out_free = !out_valid_q || point.ready;
	assign walk1    = (dx_q < dy_q);
	assign at_limit = (n_q == NW'(mepg_pkg::LIMIT_RESULTS - 1));
	assign emit     = out_free && ((state_q == ST_REG1 && walk1) || state_q == ST_REG2);
	assign last_w   = at_limit || (state_q == ST_REG2 && y_q == '0);
	assign pop_ready = (state_q == ST_IDLE);

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_SEED: begin
				op_a = OPW'(a2_q);
				op_b = OPW'(b_q);
			end
			ST_SQX: begin
				op_a = OPW'({x_q, 1'b1});
				op_b = OPW'({x_q, 1'b1});
			end
			ST_MULB: begin
				op_a = OPW'(b2_q);
				op_b = prod_q[OPW-1:0];
			end
			ST_SQY: begin
				op_a = OPW'(y_q) - OPW'(1);
				op_b = OPW'(y_q) - OPW'(1);
			end
			ST_MULA: begin
				op_a = OPW'(a2_q);
				op_b = prod_q[OPW-1:0];
			end
			ST_MULAB: begin
				op_a = OPW'(a2_q);
				op_b = OPW'(b2_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (pop_valid) state_q <= ST_SEED;
				ST_SEED:  state_q <= ST_INIT;
				ST_INIT:  state_q <= ST_REG1;
				ST_REG1: begin
					if (!walk1) begin
						state_q <= ST_SQX;
					end else if (out_free && at_limit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SQX:   state_q <= ST_MULB;
				ST_MULB:  state_q <= ST_SQY;
				ST_SQY:   state_q <= ST_MULA;
				ST_MULA:  state_q <= ST_MULAB;
				ST_MULAB: state_q <= ST_FIN;
				ST_FIN:   state_q <= ST_REG2;
				ST_REG2:  if (out_free && last_w) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				{cx_q, cy_q, b_q, a2_q, b2_q} <= pop_job;
				x_q  <= '0;
				y_q  <= YW'(pop_job[2*SQ +: R]);
				dx_q <= '0;
				n_q  <= '0;
			end
			ST_SEED: prod_q <= MW'(op_a * op_b);
			ST_INIT: begin
				dy_q <= prod_w + prod_w;
				d_q  <= (b2_w <<< 2) - (prod_w <<< 2) + a2_w;
			end
			ST_REG1: begin
				if (emit) begin
					n_q  <= n_q + 1'b1;
					x_q  <= x_q + 1'b1;
					dx_q <= dx_n;
					if (d_q[DW-1]) begin
						d_q <= d_q + ((dx_n + b2_w) <<< 2);
					end else begin
						y_q  <= y_q - 1'b1;
						dy_q <= dy_n;
						d_q  <= d_q + ((dx_n - dy_n + b2_w) <<< 2);
					end
				end
			end
			ST_SQX, ST_MULB: prod_q <= MW'(op_a * op_b);
			ST_SQY: begin
				d_q    <= prod_w;
				prod_q <= MW'(op_a * op_b);
			end
			ST_MULA: prod_q <= MW'(op_a * op_b);
			// a2*(y-1)^2 joins at MULAB, the a2*b2 term leaves at FIN
			ST_MULAB: begin
				d_q    <= d_q + (prod_w <<< 2);
				prod_q <= MW'(op_a * op_b);
			end
			ST_FIN:  d_q <= d_q - (prod_w <<< 2);
			ST_REG2: begin
				if (emit) begin
					n_q  <= n_q + 1'b1;
					y_q  <= y_q - 1'b1;
					dy_q <= dy_n;
					if (!d_q[DW-1] && d_q != '0) begin
						d_q <= d_q + ((a2_w - dy_n) <<< 2);
					end else begin
						x_q  <= x_q + 1'b1;
						dx_q <= dx_n;
						d_q  <= d_q + ((dx_n - dy_n + a2_w) <<< 2);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			offset_x_q <= x_q[R-1:0];
			offset_y_q <= y_q[R-1:0];
			x_plus_q   <= OW'(cx_q) + OW'(x_q);
			x_minus_q  <= OW'(cx_q) - OW'(x_q);
			y_plus_q   <= OW'(cy_q) + OW'(y_q);
			y_minus_q  <= OW'(cy_q) - OW'(y_q);
			last_q     <= last_w;
		end
	end

	assign point.valid      = out_valid_q;
	assign point.offset_x   = offset_x_q;
	assign point.offset_y   = offset_y_q;
	assign point.x_plus     = x_plus_q;
	assign point.x_minus    = x_minus_q;
	assign point.y_plus     = y_plus_q;
	assign point.y_minus    = y_minus_q;
	assign point.last_point = last_q;

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last_w |=> state_q == ST_IDLE)
		else $error("walk continued after last point set");
	a_y_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !y_q[YW-1])
		else $error("negative offset emitted");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !last_w |=> n_q == $past(n_q) + 1'b1)
		else $error("point count did not advance");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !point.ready |=> out_valid_q && $stable(last_q))
		else $error("pending point set lost");
`endif

endmodule

### src/midpoint_ellipse_point_generator.sv
// Path: an accepted request passes the front register, the job queue and the states
// IDLE, SEED and INIT, then REG1 emits its first point set into the output register;
// when a zero radius leaves region one empty, SQX to FIN run before REG2 emits it.
// Throughput: one point set per cycle while walking and the output is not stalled; an
// ellipse also needs the take, seeding and region change, on one shared multiplier.
// Reset: arst_n clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
// midpoint_ellipse_point_generator
// Two-region midpoint ellipse rasteriser emitting symmetric point sets.
// ----------------------------------------------------------------------------
module midpoint_ellipse_point_generator #(
	parameter int COORD_BITS  = mepg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mepg_pkg::RADIUS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mepg_in_if.sink     ellipse,
	mepg_out_if.source  point
);

	localparam int JOB_BITS = 2 * COORD_BITS + 5 * RADIUS_BITS;

	logic                push_valid;
	logic                push_ready;
	logic [JOB_BITS-1:0] push_job;
	logic                pop_valid;
	logic                pop_ready;
	logic [JOB_BITS-1:0] pop_job;

	mepg_front #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.JOB_BITS    (JOB_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ellipse    (ellipse),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	mepg_queue #(
		.WIDTH (JOB_BITS),
		.DEPTH (mepg_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_job)
	);

	mepg_back #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.JOB_BITS    (JOB_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.point     (point)
	);

endmodule
